// ----- hdl/gdpa_pkg.sv -----
package gdpa_pkg;

    localparam int NUM_PATHS_DEF = 8;
    localparam int MAX_PATHS     = 8;
    localparam int SF_BASE       = 7;
    localparam int SF_COUNT      = 6;
    localparam int SENS_W        = 11;
    localparam int MAP_W         = 24;
    localparam int CH_W          = 3;
    localparam int TAG_W         = 8;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 3;

    typedef logic signed [SENS_W-1:0] sens_t;

    localparam sens_t SENS_RESET [SF_COUNT] = '{
        sens_t'(-520), sens_t'(-530), sens_t'(-540),
        sens_t'(-550), sens_t'(-560), sens_t'(-570)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_SF7  = 3'd0,
        REG_SENS_SF8  = 3'd1,
        REG_SENS_SF9  = 3'd2,
        REG_SENS_SF10 = 3'd3,
        REG_SENS_SF11 = 3'd4,
        REG_SENS_SF12 = 3'd5,
        REG_MAP       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        FN_RX_START  = 2'd0,
        FN_RX_END    = 2'd1,
        FN_TX_START  = 2'd2,
        FN_TX_FINISH = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_LOCKED      = 4'd0,
        ST_DROP_TX     = 4'd1,
        ST_DROP_SENS   = 4'd2,
        ST_DROP_NOPATH = 4'd3,
        ST_OK          = 4'd4,
        ST_INTERFERED  = 4'd5,
        ST_INTERRUPTED = 4'd6,
        ST_TX_STARTED  = 4'd7,
        ST_TX_FINISHED = 4'd8
    } status_t;

    typedef struct packed {
        logic load;
        logic step;
        logic hit;
        logic intr;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic match;
        logic is_tx;
        logic last_idx;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/gdpa_ctrl.sv -----
module gdpa_ctrl
    import gdpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (st.skip)
                begin
                    state_next = S_FINAL;
                end
                else if (st.match && !st.is_tx)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_FINAL;
                end
                else if (st.match)
                begin
                    if (st.out_free)
                    begin
                        cmd.intr = 1'b1;
                        if (st.last_idx)
                            state_next = S_FINAL;
                        else
                            cmd.step = 1'b1;
                    end
                end
                else
                begin
                    if (st.last_idx)
                        state_next = S_FINAL;
                    else
                        cmd.step = 1'b1;
                end
            end
            S_FINAL:
            begin
                if (st.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hdl/gdpa_dp.sv -----
module gdpa_dp
    import gdpa_pkg::*;
#(
    parameter int NUM_PATHS = NUM_PATHS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MAP_W-1:0]      cfg_wdata,
    input  logic [1:0]            func,
    input  logic [CH_W-1:0]       channel,
    input  logic [3:0]            spread_factor,
    input  logic signed [SENS_W-1:0] rx_power_qdbm,
    input  logic [TAG_W-1:0]      packet_tag,
    input  logic [3:0]            destroyed_by,
    input  dp_cmd_t               cmd,
    output dp_status_t            st,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            status,
    output logic [2:0]            path_index,
    output logic                  path_found,
    output logic [TAG_W-1:0]      result_tag,
    output logic [3:0]            interferer,
    output logic [CNT_W-1:0]      busy_count,
    output logic                  last
);

    localparam int IW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;

    sens_t                 sens_reg [SF_COUNT];
    logic [MAP_W-1:0]      map_reg;
    logic [NUM_PATHS-1:0]  busy_reg;
    logic [TAG_W-1:0]      tag_mem_reg [NUM_PATHS];
    logic                  tx_reg;
    logic [CNT_W-1:0]      cnt_reg;

    func_t                 func_reg;
    logic [CH_W-1:0]       chan_reg;
    logic [3:0]            sf_reg;
    sens_t                 pwr_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [3:0]            verdict_reg;

    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         hit_reg;
    logic                  found_reg;

    logic                  out_valid_reg;
    logic [3:0]            status_reg;
    logic [2:0]            path_index_reg;
    logic                  path_found_reg;
    logic [TAG_W-1:0]      result_tag_reg;
    logic [3:0]            interferer_reg;
    logic [CNT_W-1:0]      busy_count_reg;
    logic                  last_reg;

    logic [MAP_W-1:0]      map_sh;
    logic [CH_W-1:0]       ch_at;
    logic                  match;
    logic                  sf_ok;
    logic [2:0]            sf_sel;
    sens_t                 thr;
    logic                  sens_ok;
    logic                  emit;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;

    assign map_sh = map_reg >> (5'(idx_reg) * 5'd3);
    assign ch_at  = map_sh[CH_W-1:0];

    always_comb
    begin
        unique case (func_reg)
            FN_RX_START:  match = !busy_reg[idx_reg] && (ch_at == chan_reg);
            FN_RX_END:    match = busy_reg[idx_reg] && (tag_mem_reg[idx_reg] == tag_reg);
            FN_TX_START:  match = busy_reg[idx_reg];
            default:      match = 1'b0;
        endcase
    end

    assign sf_ok   = (sf_reg >= 4'(SF_BASE)) && (sf_reg < 4'(SF_BASE + SF_COUNT));
    assign sf_sel  = sf_ok ? 3'(sf_reg - 4'(SF_BASE)) : 3'd0;
    assign thr     = sens_reg[sf_sel];
    assign sens_ok = sf_ok && (pwr_reg >= thr);

    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_dec = (cnt_reg == '0) ? cnt_reg : cnt_reg - 1'b1;

    assign st.skip     = (func_reg == FN_TX_FINISH) || ((func_reg == FN_RX_START) && tx_reg);
    assign st.match    = match;
    assign st.is_tx    = (func_reg == FN_TX_START);
    assign st.last_idx = (idx_reg == IW'(NUM_PATHS - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    assign emit = cmd.intr || cmd.fin;

    // config and path state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SF_COUNT; i++)
                sens_reg[i] <= SENS_RESET[i];
            map_reg   <= '0;
            busy_reg  <= '0;
            tx_reg    <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            hit_reg   <= '0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int i = 0; i < SF_COUNT; i++)
                    if (cfg_index == CFG_IDX_W'(i))
                        sens_reg[i] <= cfg_wdata[SENS_W-1:0];
                if (cfg_index == REG_MAP)
                    map_reg <= cfg_wdata;
            end

            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.hit)
            begin
                hit_reg   <= idx_reg;
                found_reg <= 1'b1;
            end

            if (cmd.intr)
            begin
                busy_reg[idx_reg] <= 1'b0;
                cnt_reg           <= cnt_dec;
            end

            if (cmd.fin)
            begin
                unique case (func_reg)
                    FN_RX_START:
                    begin
                        if (!tx_reg && found_reg && sens_ok)
                        begin
                            busy_reg[hit_reg] <= 1'b1;
                            cnt_reg           <= cnt_inc;
                        end
                    end
                    FN_RX_END:
                    begin
                        if (found_reg)
                        begin
                            busy_reg[hit_reg] <= 1'b0;
                            cnt_reg           <= cnt_dec;
                        end
                    end
                    FN_TX_START:  tx_reg <= 1'b1;
                    FN_TX_FINISH: tx_reg <= 1'b0;
                    default:      tx_reg <= tx_reg;
                endcase
            end

            out_valid_reg <= emit || (out_valid_reg && !out_ready);
        end
    end

    // input beat, tags and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func_t'(func);
            chan_reg    <= channel;
            sf_reg      <= spread_factor;
            pwr_reg     <= rx_power_qdbm;
            tag_reg     <= packet_tag;
            verdict_reg <= destroyed_by;
        end

        if (cmd.fin && (func_reg == FN_RX_START) && !tx_reg && found_reg && sens_ok)
            tag_mem_reg[hit_reg] <= tag_reg;

        if (cmd.intr)
        begin
            status_reg     <= ST_INTERRUPTED;
            path_index_reg <= 3'(idx_reg);
            path_found_reg <= 1'b1;
            result_tag_reg <= tag_mem_reg[idx_reg];
            interferer_reg <= '0;
            busy_count_reg <= '0;
            last_reg       <= 1'b0;
        end
        else if (cmd.fin)
        begin
            path_index_reg <= '0;
            path_found_reg <= 1'b0;
            result_tag_reg <= tag_reg;
            interferer_reg <= '0;
            busy_count_reg <= cnt_reg;
            last_reg       <= 1'b1;
            unique case (func_reg)
                FN_RX_START:
                begin
                    priority if (tx_reg)
                        status_reg <= ST_DROP_TX;
                    else if (!found_reg)
                        status_reg <= ST_DROP_NOPATH;
                    else if (!sens_ok)
                        status_reg <= ST_DROP_SENS;
                    else
                    begin
                        status_reg     <= ST_LOCKED;
                        path_index_reg <= 3'(hit_reg);
                        path_found_reg <= 1'b1;
                        busy_count_reg <= cnt_inc;
                    end
                end
                FN_RX_END:
                begin
                    status_reg     <= (verdict_reg != '0) ? ST_INTERFERED : ST_OK;
                    interferer_reg <= verdict_reg;
                    if (found_reg)
                    begin
                        path_index_reg <= 3'(hit_reg);
                        path_found_reg <= 1'b1;
                        busy_count_reg <= cnt_dec;
                    end
                end
                FN_TX_START:
                begin
                    status_reg     <= ST_TX_STARTED;
                    result_tag_reg <= '0;
                end
                default:
                begin
                    status_reg     <= ST_TX_FINISHED;
                    result_tag_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign path_index = path_index_reg;
    assign path_found = path_found_reg;
    assign result_tag = result_tag_reg;
    assign interferer = interferer_reg;
    assign busy_count = busy_count_reg;
    assign last       = last_reg;

endmodule

// ----- hdl/gateway_demod_path_allocator_top.sv -----
// The input beat is registered in the idle state; the scan, which some items skip, checks
// one path per cycle but holds on a busy path at transmit start until the output is free.
// Transmit start emits one beat per busy path during the scan, then a closing beat.
// A new item is accepted only in the idle state, after the previous item's closing beat.
// Reset (rst_n, async, active low): all paths free, not transmitting, registers at defaults.
module gateway_demod_path_allocator_top
    import gdpa_pkg::*;
#(
    parameter int NUM_PATHS = NUM_PATHS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [MAP_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic [CH_W-1:0]          channel,
    input  logic [3:0]               spread_factor,
    input  logic signed [SENS_W-1:0] rx_power_qdbm,
    input  logic [TAG_W-1:0]         packet_tag,
    input  logic [3:0]               destroyed_by,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [3:0]               status,
    output logic [2:0]               path_index,
    output logic                     path_found,
    output logic [TAG_W-1:0]         result_tag,
    output logic [3:0]               interferer,
    output logic [CNT_W-1:0]         busy_count,
    output logic                     last
);

    dp_cmd_t    cmd;
    dp_status_t st;

    gdpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    gdpa_dp #(
        .NUM_PATHS (NUM_PATHS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .channel       (channel),
        .spread_factor (spread_factor),
        .rx_power_qdbm (rx_power_qdbm),
        .packet_tag    (packet_tag),
        .destroyed_by  (destroyed_by),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .path_index    (path_index),
        .path_found    (path_found),
        .result_tag    (result_tag),
        .interferer    (interferer),
        .busy_count    (busy_count),
        .last          (last)
    );

endmodule

// ----- hdl/gdpa_checker.sv -----
module gdpa_checker
    import gdpa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [3:0]       status,
    input logic [2:0]       path_index,
    input logic             path_found,
    input logic [CNT_W-1:0] busy_count,
    input logic             last
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(path_index))
        else $error("result beat changed while stalled");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_found |->
            (status == ST_LOCKED) || (status == ST_OK) ||
            (status == ST_INTERFERED) || (status == ST_INTERRUPTED))
        else $error("path reported with a status that names no path");

    a_no_path_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !path_found |-> path_index == 3'd0)
        else $error("path index set without a path");

    a_tx_start_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TX_STARTED || status == ST_INTERRUPTED) |->
            busy_count == '0 && (last == (status == ST_TX_STARTED)))
        else $error("transmit start beat with wrong count or last flag");

endmodule

bind gateway_demod_path_allocator_top gdpa_checker u_gdpa_checker (.*);

// ----- tb/gateway_demod_path_allocator_top_test.sv -----
module gateway_demod_path_allocator_top_test;
    import gdpa_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = NUM_PATHS_DEF + 4;

    typedef struct {
        func_t           fn;
        logic [CH_W-1:0] chan;
        logic [3:0]      sf;
        sens_t           pwr;
        logic [TAG_W-1:0] tag;
        logic [3:0]      verdict;
    } rx_event_t;

    typedef struct {
        status_t          st;
        logic [2:0]       idx;
        logic             found;
        logic [TAG_W-1:0] tag;
        logic [3:0]       intf;
        logic [CNT_W-1:0] busy;
        logic             last;
    } path_result_t;

    typedef enum {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_EVERY_FOURTH,
        RDY_SPARSE
    } ready_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MAP_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           func = '0;
    logic [CH_W-1:0]      channel = '0;
    logic [3:0]           spread_factor = '0;
    logic signed [SENS_W-1:0] rx_power_qdbm = '0;
    logic [TAG_W-1:0]     packet_tag = '0;
    logic [3:0]           destroyed_by = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [3:0]           status;
    logic [2:0]           path_index;
    logic                 path_found;
    logic [TAG_W-1:0]     result_tag;
    logic [3:0]           interferer;
    logic [CNT_W-1:0]     busy_count;
    logic                 last;

    // shadow of the allocator state
    sens_t            sens_copy [SF_COUNT];
    logic [MAP_W-1:0] map_copy;
    logic             shadow_busy [MAX_PATHS];
    logic [TAG_W-1:0] shadow_tag [MAX_PATHS];
    logic             shadow_tx;
    logic [CNT_W-1:0] shadow_count;

    path_result_t results_due [$];

    int errors = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    bit offering = 1'b0;
    bit gap_due = 1'b0;
    bit no_gaps = 1'b0;
    int hold_off_len = 0;
    int idle_cycles = 0;

    gateway_demod_path_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .channel       (channel),
        .spread_factor (spread_factor),
        .rx_power_qdbm (rx_power_qdbm),
        .packet_tag    (packet_tag),
        .destroyed_by  (destroyed_by),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .path_index    (path_index),
        .path_found    (path_found),
        .result_tag    (result_tag),
        .interferer    (interferer),
        .busy_count    (busy_count),
        .last          (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
        begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic path_result_t make_result(input status_t st, input int idx,
                                                 input logic found,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [3:0] intf);
        path_result_t r;
        r.st = st;
        r.idx = 3'(idx);
        r.found = found;
        r.tag = tag;
        r.intf = intf;
        r.busy = '0;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic rx_event_t make_event(input func_t fn, input int chan, input int sf,
                                             input int pwr, input int tag, input int verdict);
        rx_event_t ev;
        ev.fn = fn;
        ev.chan = CH_W'(chan);
        ev.sf = 4'(sf);
        ev.pwr = sens_t'(pwr);
        ev.tag = TAG_W'(tag);
        ev.verdict = 4'(verdict);
        return ev;
    endfunction

    task automatic reset_shadow();
        for (int i = 0; i < SF_COUNT; i++)
        begin
            sens_copy[i] = SENS_RESET[i];
        end
        for (int i = 0; i < MAX_PATHS; i++)
        begin
            shadow_busy[i] = 1'b0;
            shadow_tag[i] = '0;
        end
        map_copy = '0;
        shadow_tx = 1'b0;
        shadow_count = '0;
    endtask

    // works out the result beats of one accepted item and queues them
    task automatic predict_path_results(input rx_event_t ev);
        path_result_t batch [$];
        path_result_t r;
        status_t st;
        int hit;
        hit = -1;
        case (ev.fn)
            FN_RX_START:
            begin
                if (shadow_tx)
                begin
                    batch.push_back(make_result(ST_DROP_TX, 0, 1'b0, ev.tag, '0));
                end
                else
                begin
                    for (int i = 0; i < NUM_PATHS_DEF; i++)
                    begin
                        if (hit < 0 && !shadow_busy[i] && map_copy[3*i +: 3] == ev.chan)
                        begin
                            hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        batch.push_back(make_result(ST_DROP_NOPATH, 0, 1'b0, ev.tag, '0));
                    end
                    else if (ev.sf < SF_BASE || ev.sf >= SF_BASE + SF_COUNT
                             || ev.pwr < sens_copy[ev.sf - SF_BASE])
                    begin
                        batch.push_back(make_result(ST_DROP_SENS, 0, 1'b0, ev.tag, '0));
                    end
                    else
                    begin
                        shadow_busy[hit] = 1'b1;
                        shadow_tag[hit] = ev.tag;
                        if (shadow_count < 15)
                        begin
                            shadow_count++;
                        end
                        batch.push_back(make_result(ST_LOCKED, hit, 1'b1, ev.tag, '0));
                    end
                end
            end
            FN_RX_END:
            begin
                st = (ev.verdict != 0) ? ST_INTERFERED : ST_OK;
                for (int i = 0; i < NUM_PATHS_DEF; i++)
                begin
                    if (hit < 0 && shadow_busy[i] && shadow_tag[i] == ev.tag)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    shadow_busy[hit] = 1'b0;
                    if (shadow_count > 0)
                    begin
                        shadow_count--;
                    end
                    batch.push_back(make_result(st, hit, 1'b1, ev.tag, ev.verdict));
                end
                else
                begin
                    batch.push_back(make_result(st, 0, 1'b0, ev.tag, ev.verdict));
                end
            end
            FN_TX_START:
            begin
                for (int i = 0; i < NUM_PATHS_DEF; i++)
                begin
                    if (shadow_busy[i])
                    begin
                        batch.push_back(make_result(ST_INTERRUPTED, i, 1'b1,
                                                    shadow_tag[i], '0));
                        shadow_busy[i] = 1'b0;
                        if (shadow_count > 0)
                        begin
                            shadow_count--;
                        end
                    end
                end
                shadow_tx = 1'b1;
                batch.push_back(make_result(ST_TX_STARTED, 0, 1'b0, '0, '0));
            end
            default:
            begin
                shadow_tx = 1'b0;
                batch.push_back(make_result(ST_TX_FINISHED, 0, 1'b0, '0, '0));
            end
        endcase
        foreach (batch[k])
        begin
            r = batch[k];
            r.busy = shadow_count;
            r.last = (k == batch.size() - 1);
            results_due.push_back(r);
        end
    endtask

    // sender: bursts of random length, with idle gaps between bursts unless gaps are turned off
    task automatic offer_event(input rx_event_t ev);
        if (gap_due)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            gap_due = 1'b0;
        end
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        func <= ev.fn;
        channel <= ev.chan;
        spread_factor <= ev.sf;
        rx_power_qdbm <= ev.pwr;
        packet_tag <= ev.tag;
        destroyed_by <= ev.verdict;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_path_results(ev);
        items_sent++;
        burst_left--;
        if (burst_left <= 0 && !no_gaps)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            gap_due = 1'b1;
        end
    endtask

    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            gap_due = 1'b1;
            burst_left = 0;
        end
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [MAP_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAP)
        begin
            map_copy = val;
        end
        else
        begin
            sens_copy[int'(idx)] = val[SENS_W-1:0];
        end
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [MAP_W-1:0] map, input int sens_lo,
                               input int sens_hi);
        int v;
        for (int i = 0; i < SF_COUNT; i++)
        begin
            v = sens_lo + int'($urandom_range(0, sens_hi - sens_lo));
            write_reg(reg_idx_t'(i), MAP_W'(v));
        end
        write_reg(REG_MAP, map);
    endtask

    // mostly well-formed traffic: receptions on mapped channels near or above
    // sensitivity, end receives on live tags, occasional transmit windows
    function automatic rx_event_t random_event();
        rx_event_t ev;
        int roll;
        int thr;
        int v;
        int busy_ids [$];
        ev.chan = CH_W'($urandom_range(0, 7));
        ev.sf = 4'($urandom_range(0, 15));
        ev.pwr = sens_t'($urandom);
        ev.tag = TAG_W'($urandom);
        ev.verdict = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (shadow_tx)
        begin
            ev.fn = (roll < 45) ? FN_TX_FINISH : (roll < 65) ? FN_RX_START :
                    (roll < 90) ? FN_RX_END : FN_TX_START;
        end
        else
        begin
            ev.fn = (roll < 50) ? FN_RX_START : (roll < 85) ? FN_RX_END :
                    (roll < 93) ? FN_TX_START : FN_TX_FINISH;
        end
        if (ev.fn == FN_RX_START)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                v = $urandom_range(0, NUM_PATHS_DEF - 1);
                ev.chan = map_copy[3*v +: 3];
            end
            if ($urandom_range(0, 9) != 0)
            begin
                ev.sf = 4'($urandom_range(SF_BASE, SF_BASE + SF_COUNT - 1));
            end
            if (ev.sf >= SF_BASE && ev.sf < SF_BASE + SF_COUNT)
            begin
                thr = int'(sens_copy[ev.sf - SF_BASE]);
                roll = $urandom_range(0, 3);
                if (roll < 2)
                begin
                    v = thr + int'($urandom_range(0, 1023 - thr));
                    ev.pwr = sens_t'(v);
                end
                else if (roll == 2)
                begin
                    v = thr + int'($urandom_range(0, 2)) - 1;
                    if (v > 1023)
                    begin
                        v = 1023;
                    end
                    if (v < -1024)
                    begin
                        v = -1024;
                    end
                    ev.pwr = sens_t'(v);
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                ev.tag = TAG_W'($urandom_range(0, 7));
            end
        end
        else if (ev.fn == FN_RX_END)
        begin
            for (int i = 0; i < NUM_PATHS_DEF; i++)
            begin
                if (shadow_busy[i])
                begin
                    busy_ids.push_back(i);
                end
            end
            if (busy_ids.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                ev.tag = shadow_tag[busy_ids[$urandom_range(0, busy_ids.size() - 1)]];
            end
            if ($urandom_range(0, 1) == 0)
            begin
                ev.verdict = '0;
            end
        end
        return ev;
    endfunction

    // all paths start on channel 0 with the reset thresholds
    task automatic test_directed_receive();
        offer_event(make_event(FN_RX_START, 0, 7, 1023, 8'hFF, 0));
        offer_event(make_event(FN_RX_START, 0, 12, -570, 8'h00, 0));   // exactly at threshold
        offer_event(make_event(FN_RX_START, 0, 12, -571, 8'h11, 0));
        offer_event(make_event(FN_RX_START, 0, 0, 1023, 8'h12, 0));     // no threshold for sf
        offer_event(make_event(FN_RX_START, 0, 15, 1023, 8'h13, 15));
        offer_event(make_event(FN_RX_START, 3, 7, -1024, 8'h14, 0));    // unmapped channel
        offer_event(make_event(FN_RX_END, 7, 9, 0, 8'hFF, 0));
        offer_event(make_event(FN_RX_END, 0, 7, 0, 8'h00, 12));
        offer_event(make_event(FN_RX_END, 0, 7, 0, 8'h55, 15));         // tag not held
        offer_event(make_event(FN_RX_START, 0, 8, 100, 8'h2A, 0));
        offer_event(make_event(FN_RX_START, 0, 9, 100, 8'h2A, 0));
        offer_event(make_event(FN_RX_END, 0, 7, 0, 8'h2A, 0));          // lowest holder freed
        for (int i = 0; i < NUM_PATHS_DEF - 1; i++)
        begin
            offer_event(make_event(FN_RX_START, 0, SF_BASE + i % SF_COUNT, 0, 8'h80 + i, 0));
        end
        offer_event(make_event(FN_RX_START, 0, 0, -1024, 8'h01, 0));    // full pool wins over sens
        settle();
    endtask

    task automatic test_directed_transmit();
        offer_event(make_event(FN_TX_START, 5, 3, -7, 8'hA5, 9));       // interrupts every path
        offer_event(make_event(FN_RX_START, 0, 7, 1023, 8'h33, 0));
        offer_event(make_event(FN_RX_END, 0, 7, 0, 8'h80, 4));
        offer_event(make_event(FN_TX_START, 0, 7, 0, 8'h00, 0));
        offer_event(make_event(FN_TX_FINISH, 7, 12, 1023, 8'hFF, 15));
        offer_event(make_event(FN_TX_FINISH, 0, 0, 0, 8'h00, 0));
        settle();
    endtask

    task automatic test_random_traffic(input logic [MAP_W-1:0] map, input int sens_lo,
                                       input int sens_hi, input int count);
        load_config(map, sens_lo, sens_hi);
        repeat (count) offer_event(random_event());
        settle();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        hold_off_len = 300;
        no_gaps = 1'b1;
        repeat (20) offer_event(random_event());
        no_gaps = 1'b0;
        settle();
    endtask

    initial
    begin : out_side
        ready_mode_t mode;
        int mode_left;
        mode = RDY_ALWAYS;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS:       out_ready <= 1'b1;
                    RDY_COIN:         out_ready <= 1'($urandom_range(0, 1));
                    RDY_EVERY_FOURTH: out_ready <= (mode_left % 4 != 0);
                    default:          out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        path_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            beats_checked++;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, status %0d", status));
            end
            else
            begin
                want = results_due.pop_front();
                check_field("status", 8'(status), 8'(want.st));
                check_field("path_index", 8'(path_index), 8'(want.idx));
                check_field("path_found", 8'(path_found), 8'(want.found));
                check_field("result_tag", result_tag, want.tag);
                check_field("interferer", 8'(interferer), 8'(want.intf));
                check_field("busy_count", 8'(busy_count), 8'(want.busy));
                check_field("last", 8'(last), 8'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("gateway_demod_path_allocator_top verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        reset_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_receive();
        test_directed_transmit();
        test_random_traffic(24'hFAC688, -600, -450, 45);
        test_output_backpressure();
        test_random_traffic(24'hFFFFFF, -1024, -1024, 45);
        test_random_traffic(MAP_W'($urandom), -1024, 1023, 45);
        test_random_traffic(MAP_W'($urandom) & 24'h249249, 1023, 1023, 45);
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d result beats never arrived", results_due.size()));
        end
        $display("summary: %0d items, %0d result beats, %0d register writes, %0d errors",
                 items_sent, beats_checked, cfg_writes, errors);
        $display("summary: reset, one-per-channel, all-on-7, random and two-channel maps; "
                 , "sensitivity at both extremes; one long output hold-off");
        if (errors == 0)
        begin
            $display("gateway_demod_path_allocator_top verification clean");
        end
        else
        begin
            $display("gateway_demod_path_allocator_top verification failed");
        end
        $finish;
    end

endmodule
